FILE: sv/assert_macros.svh
// Assertion macros shared by the reel click position controller RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define RCPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that stays armed during reset.
`define RCPC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: sv/rcpc_pkg.sv
// Package for the reel click position controller: codes, constants and
// the configuration, item and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcpc_pkg;

  localparam int unsigned DW = 16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_CLICK = 2'd1,
    MODE_LIMIT = 2'd2,
    MODE_PWM   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    MOVE_IDLE    = 3'd0,
    MOVE_DOWN    = 3'd1,
    MOVE_UP      = 3'd2,
    MOVE_TIMEOUT = 3'd3,
    MOVE_LIMIT   = 3'd4
  } move_t;

  typedef enum logic [1:0] {
    EVT_NONE      = 2'd0,
    EVT_HOMED     = 2'd1,
    EVT_LIMIT_ERR = 2'd2,
    EVT_OOB       = 2'd3
  } evt_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_PWM_NEUTRAL     = 3'd0;
  localparam logic [2:0] CFG_MOTOR_UP_DUTY   = 3'd1;
  localparam logic [2:0] CFG_MOTOR_DOWN_DUTY = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT_FINE    = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT_COARSE  = 3'd4;
  localparam logic [2:0] CFG_HOME_WINDOW     = 3'd5;
  localparam logic [2:0] CFG_MAX_DEPTH       = 3'd6;
  localparam logic [2:0] CFG_MIN_DEPTH       = 3'd7;

  // Configuration reset values
  localparam logic [DW-1:0]        RST_PWM_NEUTRAL     = 16'd3000;
  localparam logic [DW-1:0]        RST_MOTOR_UP_DUTY   = 16'd4000;
  localparam logic [DW-1:0]        RST_MOTOR_DOWN_DUTY = 16'd2000;
  localparam logic [DW-1:0]        RST_TIMEOUT_FINE    = 16'd1000;
  localparam logic [DW-1:0]        RST_TIMEOUT_COARSE  = 16'd100;
  localparam logic signed [DW-1:0] RST_HOME_WINDOW     = 16'sd10;
  localparam logic signed [DW-1:0] RST_MAX_DEPTH       = 16'sd1000;
  localparam logic signed [DW-1:0] RST_MIN_DEPTH       = 16'sd0;

  // Capture timer values above this restart the timer on a rising edge
  localparam logic [DW-1:0]        WRAP_LIMIT    = 16'hFFFF - 16'd4000;
  localparam logic signed [DW-1:0] PULLUP_TARGET = -16'sd10;
  localparam logic signed [DW-1:0] DEPTH_MAX     = 16'sh7FFF;
  localparam logic signed [DW-1:0] DEPTH_MIN     = 16'sh8000;

  typedef struct packed {
    logic [DW-1:0]        pwm_neutral;
    logic [DW-1:0]        motor_up_duty;
    logic [DW-1:0]        motor_down_duty;
    logic [DW-1:0]        timeout_fine;
    logic [DW-1:0]        timeout_coarse;
    logic signed [DW-1:0] home_window;
    logic signed [DW-1:0] max_depth;
    logic signed [DW-1:0] min_depth;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic signed [DW-1:0] target_click;
    logic                 limit_open;
    logic                 pwm_level;
    logic [DW-1:0]        timer_value;
    logic                 arm;
  } item_t;

  typedef struct packed {
    logic [DW-1:0]        motor_duty;
    logic [DW-1:0]        actuator_duty;
    move_t                move_code;
    evt_t                 event_code;
    logic                 all_stop;
    logic signed [DW-1:0] depth;
    logic signed [DW-1:0] held_target;
    logic                 timer_restart;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/rcpc_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rcpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] target_click;
  logic               limit_open;
  logic               pwm_level;
  logic [15:0]        timer_value;
  logic               arm;

  modport source (
    output valid, mode, target_click, limit_open, pwm_level, timer_value, arm,
    input  ready
  );
  modport sink (
    input  valid, mode, target_click, limit_open, pwm_level, timer_value, arm,
    output ready
  );
endinterface

interface rcpc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        motor_duty;
  logic [15:0]        actuator_duty;
  logic [2:0]         move_code;
  logic [1:0]         event_code;
  logic               all_stop;
  logic signed [15:0] depth;
  logic signed [15:0] held_target;
  logic               timer_restart;

  modport source (
    output valid, motor_duty, actuator_duty, move_code, event_code, all_stop,
           depth, held_target, timer_restart,
    input  ready
  );
  modport sink (
    input  valid, motor_duty, actuator_duty, move_code, event_code, all_stop,
           depth, held_target, timer_restart,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/rcpc_cfg.sv
// Configuration register bank of the reel click position controller.
// Depends on rcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcpc_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [15:0]         cfg_wdata,
  output rcpc_pkg::cfg_t           cfg
);

  rcpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_neutral     <= rcpc_pkg::RST_PWM_NEUTRAL;
      cfg_r.motor_up_duty   <= rcpc_pkg::RST_MOTOR_UP_DUTY;
      cfg_r.motor_down_duty <= rcpc_pkg::RST_MOTOR_DOWN_DUTY;
      cfg_r.timeout_fine    <= rcpc_pkg::RST_TIMEOUT_FINE;
      cfg_r.timeout_coarse  <= rcpc_pkg::RST_TIMEOUT_COARSE;
      cfg_r.home_window     <= rcpc_pkg::RST_HOME_WINDOW;
      cfg_r.max_depth       <= rcpc_pkg::RST_MAX_DEPTH;
      cfg_r.min_depth       <= rcpc_pkg::RST_MIN_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rcpc_pkg::CFG_PWM_NEUTRAL:     cfg_r.pwm_neutral     <= cfg_wdata;
        rcpc_pkg::CFG_MOTOR_UP_DUTY:   cfg_r.motor_up_duty   <= cfg_wdata;
        rcpc_pkg::CFG_MOTOR_DOWN_DUTY: cfg_r.motor_down_duty <= cfg_wdata;
        rcpc_pkg::CFG_TIMEOUT_FINE:    cfg_r.timeout_fine    <= cfg_wdata;
        rcpc_pkg::CFG_TIMEOUT_COARSE:  cfg_r.timeout_coarse  <= cfg_wdata;
        rcpc_pkg::CFG_HOME_WINDOW:     cfg_r.home_window     <= $signed(cfg_wdata);
        rcpc_pkg::CFG_MAX_DEPTH:       cfg_r.max_depth       <= $signed(cfg_wdata);
        rcpc_pkg::CFG_MIN_DEPTH:       cfg_r.min_depth       <= $signed(cfg_wdata);
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/rcpc_core.sv
// Controller state and per-event update logic: depth, direction, flags,
// timeout counters, pulse measurement and duties. Depends on rcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rcpc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire rcpc_pkg::item_t   item,
  input  wire rcpc_pkg::cfg_t    cfg,
  output rcpc_pkg::result_t      res
);

  logic signed [15:0] depth_r, depth_nxt;
  rcpc_pkg::dir_t     dir_r, dir_nxt;
  logic               run_r, run_nxt;
  logic               pullup_r, pullup_nxt;
  logic [15:0]        fine_r, fine_nxt;
  logic [15:0]        coarse_r, coarse_nxt;
  logic [15:0]        pstart_r, pstart_nxt;
  logic [15:0]        pwidth_r, pwidth_nxt;
  rcpc_pkg::evt_t     evt_r, evt_nxt;
  logic               stop_r, stop_nxt;
  logic signed [15:0] target_r, target_nxt;
  logic [15:0]        motor_r, motor_nxt;
  logic [15:0]        act_r, act_nxt;

  rcpc_pkg::move_t    move;
  logic               restart;
  logic [15:0]        fine_inc;
  logic signed [15:0] depth_step;

  always_comb begin
    depth_nxt  = depth_r;
    dir_nxt    = dir_r;
    run_nxt    = run_r;
    pullup_nxt = pullup_r;
    fine_nxt   = fine_r;
    coarse_nxt = coarse_r;
    pstart_nxt = pstart_r;
    pwidth_nxt = pwidth_r;
    evt_nxt    = evt_r;
    stop_nxt   = stop_r;
    target_nxt = target_r;
    motor_nxt  = motor_r;
    act_nxt    = act_r;
    move       = rcpc_pkg::MOVE_IDLE;
    restart    = 1'b0;
    fine_inc   = fine_r + 16'd1;
    depth_step = depth_r;

    unique case (item.mode)
      rcpc_pkg::MODE_TICK: begin
        run_nxt = run_r | item.arm;
        if (fine_inc > cfg.timeout_fine) begin
          fine_nxt   = '0;
          coarse_nxt = coarse_r + 16'd1;
        end else begin
          fine_nxt = fine_inc;
        end
        priority if (coarse_nxt > cfg.timeout_coarse) begin
          stop_nxt = 1'b1;
          move     = rcpc_pkg::MOVE_TIMEOUT;
        end else if (depth_r != item.target_click && item.limit_open) begin
          if (depth_r > item.target_click) begin
            dir_nxt   = rcpc_pkg::DIR_DOWN;
            motor_nxt = cfg.motor_down_duty;
            move      = rcpc_pkg::MOVE_DOWN;
          end else begin
            dir_nxt   = rcpc_pkg::DIR_UP;
            motor_nxt = cfg.motor_up_duty;
            move      = rcpc_pkg::MOVE_UP;
          end
        end else begin
          // arrived or limit pressed: park at neutral
          dir_nxt   = rcpc_pkg::DIR_IDLE;
          run_nxt   = 1'b0;
          act_nxt   = cfg.pwm_neutral;
          motor_nxt = cfg.pwm_neutral;
          stop_nxt  = 1'b1;
          if (!item.limit_open) begin
            evt_nxt = rcpc_pkg::EVT_LIMIT_ERR;
            move    = rcpc_pkg::MOVE_LIMIT;
          end
        end
      end

      rcpc_pkg::MODE_CLICK: begin
        // saturate at the ends of the signed range
        if (dir_r == rcpc_pkg::DIR_UP && run_r && depth_r != rcpc_pkg::DEPTH_MAX)
          depth_step = depth_r + 16'sd1;
        if (dir_r == rcpc_pkg::DIR_DOWN && run_r && depth_r != rcpc_pkg::DEPTH_MIN)
          depth_step = depth_r - 16'sd1;
        if (depth_step > cfg.max_depth) begin
          stop_nxt = 1'b1;
          run_nxt  = 1'b0;
          evt_nxt  = rcpc_pkg::EVT_OOB;
        end
        depth_nxt  = (depth_step < cfg.min_depth) ? '0 : depth_step;
        fine_nxt   = '0;
        coarse_nxt = '0;
      end

      rcpc_pkg::MODE_LIMIT: begin
        run_nxt  = 1'b0;
        stop_nxt = 1'b1;
        if (dir_r != rcpc_pkg::DIR_IDLE && run_r && depth_r < cfg.home_window) begin
          depth_nxt = '0;
          dir_nxt   = rcpc_pkg::DIR_IDLE;
          evt_nxt   = pullup_r ? rcpc_pkg::EVT_NONE : rcpc_pkg::EVT_HOMED;
        end else begin
          evt_nxt = rcpc_pkg::EVT_LIMIT_ERR;
        end
      end

      rcpc_pkg::MODE_PWM: begin
        if (item.pwm_level) begin
          if (item.timer_value > rcpc_pkg::WRAP_LIMIT) begin
            restart    = 1'b1;
            pstart_nxt = '0;
          end else begin
            pstart_nxt = item.timer_value;
          end
        end else begin
          pwidth_nxt = item.timer_value - pstart_r;
        end
        if (pwidth_nxt < cfg.pwm_neutral) begin
          target_nxt = rcpc_pkg::PULLUP_TARGET;
          run_nxt    = 1'b1;
          dir_nxt    = rcpc_pkg::DIR_DOWN;
          stop_nxt   = 1'b0;
          pullup_nxt = 1'b1;
          fine_nxt   = '0;
          coarse_nxt = '0;
        end else if (pullup_r) begin
          // leave pull-up: hold at the current depth
          run_nxt    = 1'b0;
          evt_nxt    = rcpc_pkg::EVT_NONE;
          target_nxt = depth_r;
          stop_nxt   = 1'b1;
          pullup_nxt = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      dir_r    <= rcpc_pkg::DIR_IDLE;
      run_r    <= 1'b0;
      pullup_r <= 1'b0;
      fine_r   <= '0;
      coarse_r <= '0;
      pstart_r <= '0;
      pwidth_r <= '0;
      evt_r    <= rcpc_pkg::EVT_NONE;
      stop_r   <= 1'b1;
      target_r <= '0;
      motor_r  <= '0;
      act_r    <= '0;
    end else if (step_en) begin
      depth_r  <= depth_nxt;
      dir_r    <= dir_nxt;
      run_r    <= run_nxt;
      pullup_r <= pullup_nxt;
      fine_r   <= fine_nxt;
      coarse_r <= coarse_nxt;
      pstart_r <= pstart_nxt;
      pwidth_r <= pwidth_nxt;
      evt_r    <= evt_nxt;
      stop_r   <= stop_nxt;
      target_r <= target_nxt;
      motor_r  <= motor_nxt;
      act_r    <= act_nxt;
    end
  end

  always_comb begin
    res.motor_duty    = motor_nxt;
    res.actuator_duty = act_nxt;
    res.move_code     = move;
    res.event_code    = evt_nxt;
    res.all_stop      = stop_nxt;
    res.depth         = depth_nxt;
    res.held_target   = target_nxt;
    res.timer_restart = restart;
  end

  `RCPC_ASSERT(a_pullup_target, clk, rst_n,
    pullup_r |-> target_r == rcpc_pkg::PULLUP_TARGET,
    "pull-up active without pull-up target")
  `RCPC_ASSERT(a_limit_stops, clk, rst_n,
    step_en && item.mode == rcpc_pkg::MODE_LIMIT |=> !run_r && stop_r,
    "limit event left the reel running")
  `RCPC_ASSERT(a_restart_src, clk, rst_n,
    res.timer_restart |-> item.mode == rcpc_pkg::MODE_PWM && item.pwm_level,
    "timer restart outside a rising pwm edge")

endmodule

`default_nettype wire

FILE: sv/reel_click_position_controller.sv
// Reel click position controller: takes one event per cycle unless the output
// stalls (tick, encoder click, limit-switch edge or PWM input edge) and returns
// one result per event via an input register, then a result register. The
// state update between those registers is combinational. Configuration is
// written through a plain write port; the user must do so only while no event
// is in flight, which the block itself does not enforce. Depends on rcpc_pkg,
// rcpc_if, rcpc_cfg and rcpc_core.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module reel_click_position_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rcpc_in_if.sink          in_ch,
  rcpc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  rcpc_pkg::cfg_t    cfg;
  rcpc_pkg::item_t   item_r;
  rcpc_pkg::result_t res;
  rcpc_pkg::result_t res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;

  rcpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // move the held transaction into the result register when it is free
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  rcpc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready)
        in_valid_r <= in_ch.valid;
      if (advance)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      item_r.mode         <= rcpc_pkg::mode_t'(in_ch.mode);
      item_r.target_click <= in_ch.target_click;
      item_r.limit_open   <= in_ch.limit_open;
      item_r.pwm_level    <= in_ch.pwm_level;
      item_r.timer_value  <= in_ch.timer_value;
      item_r.arm          <= in_ch.arm;
    end
    if (advance)
      res_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.motor_duty    = res_r.motor_duty;
  assign out_ch.actuator_duty = res_r.actuator_duty;
  assign out_ch.move_code     = res_r.move_code;
  assign out_ch.event_code    = res_r.event_code;
  assign out_ch.all_stop      = res_r.all_stop;
  assign out_ch.depth         = res_r.depth;
  assign out_ch.held_target   = res_r.held_target;
  assign out_ch.timer_restart = res_r.timer_restart;

  `RCPC_ASSERT(a_hold_item, clk, rst_n,
    in_valid_r && !advance |=> in_valid_r && $stable(item_r),
    "held transaction lost while result register busy")
  `RCPC_ASSERT(a_hold_result, clk, rst_n,
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(res_r),
    "stalled result changed")
  `RCPC_ASSERT_NR(a_reset_empty, clk,
    !rst_n |=> !out_valid_r && !in_valid_r,
    "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: test/reel_click_position_controller_tb.sv
// Self-checking bench for reel_click_position_controller: directed events, random
// event mixes under several register settings, then a stall-free tick and click run.
// Depends on rcpc_pkg, rcpc_if and the controller RTL.
`timescale 1ns / 1ps

module reel_click_position_controller_tb;
  import rcpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20_000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    item_t   ev;
    logic    known;
    result_t want;
  } step_t;

  localparam cfg_t DEFAULT_SET = '{RST_PWM_NEUTRAL, RST_MOTOR_UP_DUTY, RST_MOTOR_DOWN_DUTY,
                                   RST_TIMEOUT_FINE, RST_TIMEOUT_COARSE, RST_HOME_WINDOW,
                                   RST_MAX_DEPTH, RST_MIN_DEPTH};
  localparam cfg_t ZERO_SET    = '0;
  localparam cfg_t FULL_SET    = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'sh7FFF, 16'sh7FFF, 16'sh8000};
  localparam cfg_t TIGHT_SET   = '{16'd3000, 16'd4000, 16'd2000, 16'd2, 16'd3,
                                   16'sd10, 16'sd20, -16'sd5};

  // Directed events; the typed results hold right after reset with default registers.
  localparam step_t SCRIPT [19] = '{
    '{'{MODE_CLICK, 16'sd0, 1'b1, 1'b0, 16'd0, 1'b0}, 1'b1,
      '{16'd0, 16'd0, MOVE_IDLE, EVT_NONE, 1'b1, 16'sd0, 16'sd0, 1'b0}},
    '{'{MODE_LIMIT, 16'sh7FFF, 1'b0, 1'b1, 16'hFFFF, 1'b1}, 1'b1,
      '{16'd0, 16'd0, MOVE_IDLE, EVT_LIMIT_ERR, 1'b1, 16'sd0, 16'sd0, 1'b0}},
    '{'{MODE_TICK, 16'sd0, 1'b1, 1'b0, 16'd0, 1'b0}, 1'b1,
      '{16'd3000, 16'd3000, MOVE_IDLE, EVT_LIMIT_ERR, 1'b1, 16'sd0, 16'sd0, 1'b0}},
    '{'{MODE_TICK, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b1,
      '{16'd3000, 16'd3000, MOVE_LIMIT, EVT_LIMIT_ERR, 1'b1, 16'sd0, 16'sd0, 1'b0}},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b1, 16'hFFFF, 1'b0}, 1'b1,
      '{16'd3000, 16'd3000, MOVE_IDLE, EVT_LIMIT_ERR, 1'b0, 16'sd0, -16'sd10, 1'b1}},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b1, WRAP_LIMIT, 1'b0}, 1'b0, '0},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b0, 16'd64535, 1'b0}, 1'b0, '0},
    '{'{MODE_TICK, 16'sh7FFF, 1'b1, 1'b0, 16'd0, 1'b1}, 1'b0, '0},
    '{'{MODE_CLICK, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_CLICK, 16'shFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{MODE_TICK, 16'sh8000, 1'b1, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_CLICK, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_LIMIT, 16'sd0, 1'b1, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b0, 16'd61635, 1'b0}, 1'b0, '0},
    '{'{MODE_CLICK, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_LIMIT, 16'sd0, 1'b0, 1'b0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_PWM, 16'sd0, 1'b0, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
    '{'{MODE_TICK, -16'sd10, 1'b1, 1'b0, 16'h5A5A, 1'b0}, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  logic        quiet;

  rcpc_in_if  in_ch ();
  rcpc_out_if out_ch ();

  reel_click_position_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies
  logic [15:0]        neutral_w  = RST_PWM_NEUTRAL;
  logic [15:0]        up_duty    = RST_MOTOR_UP_DUTY;
  logic [15:0]        down_duty  = RST_MOTOR_DOWN_DUTY;
  logic [15:0]        fine_lim   = RST_TIMEOUT_FINE;
  logic [15:0]        coarse_lim = RST_TIMEOUT_COARSE;
  logic signed [15:0] home_win   = RST_HOME_WINDOW;
  logic signed [15:0] depth_hi   = RST_MAX_DEPTH;
  logic signed [15:0] depth_lo   = RST_MIN_DEPTH;

  // Controller state as it should be after every accepted transaction
  logic signed [15:0] depth_now  = '0;
  dir_t               heading    = DIR_IDLE;
  logic               running    = 1'b0;
  logic               pulling_up = 1'b0;
  logic [15:0]        fine_cnt   = '0;
  logic [15:0]        coarse_cnt = '0;
  logic [15:0]        pulse_from = '0;
  logic [15:0]        pulse_len  = '0;
  evt_t               evt_now    = EVT_NONE;
  logic               halt_now   = 1'b1;
  logic signed [15:0] held_now   = '0;
  logic [15:0]        motor_now  = '0;
  logic [15:0]        act_now    = '0;
  logic               pwm_hi     = 1'b0;

  result_t     status_due [$];
  int unsigned faults;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("reel_click_position_controller_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
  end

  function automatic result_t next_reel_status(item_t e);
    result_t r;
    logic    restart;
    move_t   mv;
    restart = 1'b0;
    mv      = MOVE_IDLE;
    case (e.mode)
      MODE_TICK: begin
        if (e.arm) running = 1'b1;
        fine_cnt = fine_cnt + 16'd1;
        if (fine_cnt > fine_lim) begin
          fine_cnt   = '0;
          coarse_cnt = coarse_cnt + 16'd1;
        end
        if (coarse_cnt > coarse_lim) begin
          halt_now = 1'b1;
          mv       = MOVE_TIMEOUT;
        end else if (depth_now != $signed(e.target_click) && e.limit_open) begin
          if (depth_now > $signed(e.target_click)) begin
            heading   = DIR_DOWN;
            motor_now = down_duty;
            mv        = MOVE_DOWN;
          end else begin
            heading   = DIR_UP;
            motor_now = up_duty;
            mv        = MOVE_UP;
          end
        end else begin
          heading   = DIR_IDLE;
          running   = 1'b0;
          act_now   = neutral_w;
          motor_now = neutral_w;
          halt_now  = 1'b1;
          if (!e.limit_open) begin
            evt_now = EVT_LIMIT_ERR;
            mv      = MOVE_LIMIT;
          end
        end
      end
      MODE_CLICK: begin
        if (heading == DIR_UP && running && depth_now != DEPTH_MAX)
          depth_now = depth_now + 16'sd1;
        if (heading == DIR_DOWN && running && depth_now != DEPTH_MIN)
          depth_now = depth_now - 16'sd1;
        if (depth_now > depth_hi) begin
          halt_now = 1'b1;
          running  = 1'b0;
          evt_now  = EVT_OOB;
        end
        if (depth_now < depth_lo) depth_now = '0;
        fine_cnt   = '0;
        coarse_cnt = '0;
      end
      MODE_LIMIT: begin
        if (heading != DIR_IDLE && running && depth_now < home_win) begin
          depth_now = '0;
          heading   = DIR_IDLE;
          if (pulling_up) evt_now = EVT_NONE;
          else evt_now = EVT_HOMED;
        end else begin
          evt_now = EVT_LIMIT_ERR;
        end
        running  = 1'b0;
        halt_now = 1'b1;
      end
      default: begin
        pwm_hi = e.pwm_level;
        if (e.pwm_level) begin
          if (e.timer_value > WRAP_LIMIT) begin
            restart    = 1'b1;
            pulse_from = '0;
          end else begin
            pulse_from = e.timer_value;
          end
        end else begin
          pulse_len = e.timer_value - pulse_from;
        end
        if (pulse_len < neutral_w) begin
          held_now   = PULLUP_TARGET;
          running    = 1'b1;
          heading    = DIR_DOWN;
          halt_now   = 1'b0;
          pulling_up = 1'b1;
          fine_cnt   = '0;
          coarse_cnt = '0;
        end else if (pulling_up) begin
          running    = 1'b0;
          evt_now    = EVT_NONE;
          held_now   = depth_now;
          halt_now   = 1'b1;
          pulling_up = 1'b0;
        end
      end
    endcase
    r.motor_duty    = motor_now;
    r.actuator_duty = act_now;
    r.move_code     = mv;
    r.event_code    = evt_now;
    r.all_stop      = halt_now;
    r.depth         = depth_now;
    r.held_target   = held_now;
    r.timer_restart = restart;
    return r;
  endfunction

  // Mostly plausible event streams: ticks aimed near the depth, clicks, pulse pairs
  // around neutral; fields not set by the chosen kind keep random noise.
  function automatic item_t pick_event();
    item_t       e;
    int unsigned roll;
    int unsigned offs;
    e.target_click = 16'($urandom);
    e.limit_open   = 1'($urandom);
    e.pwm_level    = 1'($urandom);
    e.timer_value  = 16'($urandom);
    e.arm          = 1'($urandom);
    roll = $urandom_range(99);
    if (roll < 35) begin
      e.mode       = MODE_TICK;
      e.limit_open = ($urandom_range(9) != 0);
      e.arm        = running ? ($urandom_range(7) == 0) : ($urandom_range(2) != 0);
      offs         = $urandom_range(12);
      if ($urandom_range(3) != 0) e.target_click = 16'(depth_now + offs - 6);
    end else if (roll < 65) begin
      e.mode = MODE_CLICK;
    end else if (roll < 72) begin
      e.mode = MODE_LIMIT;
    end else begin
      e.mode = MODE_PWM;
      if ($urandom_range(9) != 0) e.pwm_level = !pwm_hi;
      offs = $urandom_range(400);
      if (e.pwm_level && $urandom_range(4) == 0)
        e.timer_value = 16'($urandom_range(16'hFFFF, WRAP_LIMIT - 16'd4));
      else if (e.pwm_level)
        e.timer_value = 16'($urandom_range(WRAP_LIMIT));
      else if ($urandom_range(4) != 0)
        e.timer_value = 16'(pulse_from + neutral_w + offs - 200);
    end
    return e;
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    s.pwm_neutral     = 16'($urandom_range(6000, 500));
    s.motor_up_duty   = 16'($urandom);
    s.motor_down_duty = 16'($urandom);
    s.timeout_fine    = 16'($urandom_range(20));
    s.timeout_coarse  = 16'($urandom_range(20));
    s.home_window     = 16'($urandom_range(40) - 10);
    s.max_depth       = 16'($urandom_range(60));
    s.min_depth       = 16'(-$urandom_range(5));
    return s;
  endfunction

  // Caller sits on a falling edge; returns on the falling edge after the transaction.
  task automatic send_event(input item_t e, input logic known, input result_t want);
    result_t guess;
    while (!quiet && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= e.mode;
    in_ch.target_click <= e.target_click;
    in_ch.limit_open   <= e.limit_open;
    in_ch.pwm_level    <= e.pwm_level;
    in_ch.timer_value  <= e.timer_value;
    in_ch.arm          <= e.arm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = next_reel_status(e);
    status_due.push_back(known ? want : guess);
    @(negedge clk);
  endtask

  task automatic hold_event(input item_t e, input int unsigned n);
    repeat (n) send_event(e, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_PWM_NEUTRAL:     neutral_w  = v;
      CFG_MOTOR_UP_DUTY:   up_duty    = v;
      CFG_MOTOR_DOWN_DUTY: down_duty  = v;
      CFG_TIMEOUT_FINE:    fine_lim   = v;
      CFG_TIMEOUT_COARSE:  coarse_lim = v;
      CFG_HOME_WINDOW:     home_win   = v;
      CFG_MAX_DEPTH:       depth_hi   = v;
      default:             depth_lo   = v;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_PWM_NEUTRAL, s.pwm_neutral);
    write_reg(CFG_MOTOR_UP_DUTY, s.motor_up_duty);
    write_reg(CFG_MOTOR_DOWN_DUTY, s.motor_down_duty);
    write_reg(CFG_TIMEOUT_FINE, s.timeout_fine);
    write_reg(CFG_TIMEOUT_COARSE, s.timeout_coarse);
    write_reg(CFG_HOME_WINDOW, s.home_window);
    write_reg(CFG_MAX_DEPTH, s.max_depth);
    write_reg(CFG_MIN_DEPTH, s.min_depth);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait out every pending result plus the pipeline depth.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.motor_duty    = out_ch.motor_duty;
      got.actuator_duty = out_ch.actuator_duty;
      got.move_code     = move_t'(out_ch.move_code);
      got.event_code    = evt_t'(out_ch.event_code);
      got.all_stop      = out_ch.all_stop;
      got.depth         = out_ch.depth;
      got.held_target   = out_ch.held_target;
      got.timer_restart = out_ch.timer_restart;
      if (status_due.size() == 0) begin
        faults <= faults + 1;
        if (faults < REPORT_MAX)
          $display("%0t: result with no transaction pending, depth=%0d", $realtime, got.depth);
      end else begin
        want = status_due.pop_front();
        if (got !== want) begin
          faults <= faults + 1;
          if (faults < REPORT_MAX) begin
            $display("%0t: exp motor=%0d act=%0d move=%0d evt=%0d stop=%0d depth=%0d held=%0d rst=%0d",
                     $realtime, want.motor_duty, want.actuator_duty, want.move_code,
                     want.event_code, want.all_stop, want.depth, want.held_target,
                     want.timer_restart);
            $display("%0t: got motor=%0d act=%0d move=%0d evt=%0d stop=%0d depth=%0d held=%0d rst=%0d",
                     $realtime, got.motor_duty, got.actuator_duty, got.move_code,
                     got.event_code, got.all_stop, got.depth, got.held_target,
                     got.timer_restart);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned idx;
    int unsigned phase;
    cfg_t        s;
    item_t       e;
    faults             = 0;
    cycle_count        = 0;
    quiet              = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TICK;
    in_ch.target_click = '0;
    in_ch.limit_open   = 1'b1;
    in_ch.pwm_level    = 1'b0;
    in_ch.timer_value  = '0;
    in_ch.arm          = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (idx = 0; idx < 19; idx++)
      send_event(SCRIPT[idx].ev, SCRIPT[idx].known, SCRIPT[idx].want);
    settle();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       s = DEFAULT_SET;
        1:       s = ZERO_SET;
        2:       s = FULL_SET;
        3:       s = TIGHT_SET;
        default: s = rand_settings();
      endcase
      load_settings(s);
      repeat (PHASE_ITEMS) send_event(pick_event(), 1'b0, '0);
      settle();
    end

    // Stall-free run with tight limits: climb past the depth ceiling, wind down
    // through the floor clamp, then tick on into the timeout.
    quiet = 1'b1;
    load_settings(TIGHT_SET);
    e = '{mode: MODE_CLICK, target_click: 16'sd0, limit_open: 1'b1,
          pwm_level: 1'b0, timer_value: 16'd0, arm: 1'b0};
    send_event(e, 1'b0, '0);
    send_event('{mode: MODE_TICK, target_click: DEPTH_MAX, limit_open: 1'b1,
                 pwm_level: 1'b0, timer_value: 16'd0, arm: 1'b1}, 1'b0, '0);
    hold_event(e, 40);
    send_event('{mode: MODE_TICK, target_click: DEPTH_MIN, limit_open: 1'b1,
                 pwm_level: 1'b0, timer_value: 16'd0, arm: 1'b1}, 1'b0, '0);
    hold_event(e, 40);
    hold_event('{mode: MODE_TICK, target_click: DEPTH_MAX, limit_open: 1'b1,
                 pwm_level: 1'b0, timer_value: 16'd0, arm: 1'b0}, 40);
    settle();

    if (faults == 0 && status_due.size() == 0) begin
      $display("reel_click_position_controller_tb: clean");
    end else begin
      $display("reel_click_position_controller_tb: errors");
    end
    $finish;
  end

endmodule
